// File: rtl/lbpm_pkg.sv
// Shared types, constants and helper functions of the light-bar pair matcher.
// Used by every module of the block; has no dependencies of its own.
`default_nettype none

package lbpm_pkg;

   localparam int FRAC_BITS = 4;
   localparam int SMALL_ASPECT_MIN_TENTHS = 10;
   localparam int LARGE_ASPECT_MAX_TENTHS = 50;
   localparam int TENTH_SCALE = 10;

   localparam int COORD_W = 16;
   localparam int ANGLE_W = 12;
   localparam int WHOLE_W = COORD_W - FRAC_BITS + 1;
   localparam int TENTH_W = COORD_W + 4;
   localparam int PROD_W = COORD_W + 8;
   localparam int ANGLE_LIM_W = 11;
   localparam int ANGLE10_W = 16;
   localparam int ANGLE_GATE_W = ANGLE_LIM_W + FRAC_BITS;
   localparam int SQ_W = 2 * WHOLE_W;
   localparam int SUM_W = SQ_W + 1;
   localparam int MH2_W = 2 * COORD_W;
   localparam int KT2_W = 16;
   localparam int LHS_W = SUM_W + 15;
   localparam int THR_W = MH2_W + KT2_W;

   localparam int ASPECT_SCALE = 100 * (1 << (2 * FRAC_BITS));
   localparam int SMALL_SQ = SMALL_ASPECT_MIN_TENTHS * SMALL_ASPECT_MIN_TENTHS;
   localparam int LARGE_SQ = LARGE_ASPECT_MAX_TENTHS * LARGE_ASPECT_MAX_TENTHS;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 11;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HEIGHT_RATIO_MIN = 3'd0,
      CSR_HEIGHT_RATIO_MAX = 3'd1,
      CSR_WIDTH_RATIO_MIN  = 3'd2,
      CSR_WIDTH_RATIO_MAX  = 3'd3,
      CSR_Y_OFFSET_LIMIT   = 3'd4,
      CSR_HEIGHT_GAP_LIMIT = 3'd5,
      CSR_ANGLE_GAP_LIMIT  = 3'd6,
      CSR_TYPE_SPLIT       = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [7:0]             height_ratio_min;
      logic [7:0]             height_ratio_max;
      logic [7:0]             width_ratio_min;
      logic [7:0]             width_ratio_max;
      logic [7:0]             y_offset_limit;
      logic [7:0]             height_gap_limit;
      logic [ANGLE_LIM_W-1:0] angle_gap_limit;
      logic [7:0]             type_split;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      height_ratio_min: 8'd5,
      height_ratio_max: 8'd20,
      width_ratio_min:  8'd5,
      width_ratio_max:  8'd20,
      y_offset_limit:   8'd5,
      height_gap_limit: 8'd5,
      angle_gap_limit:  11'd100,
      type_split:       8'd32
   };

   typedef struct packed {
      logic [COORD_W-1:0]        first_x;
      logic [COORD_W-1:0]        first_y;
      logic [COORD_W-1:0]        first_w;
      logic [COORD_W-1:0]        first_h;
      logic signed [ANGLE_W-1:0] first_angle;
      logic [COORD_W-1:0]        second_x;
      logic [COORD_W-1:0]        second_y;
      logic [COORD_W-1:0]        second_w;
      logic [COORD_W-1:0]        second_h;
      logic signed [ANGLE_W-1:0] second_angle;
   } req_word_type;

   typedef struct packed {
      logic pair_matched;
      logic large_plate;
      logic first_is_left;
   } rsp_word_type;

   typedef struct packed {
      logic               first_is_left;
      logic               not_coincident;
      logic [COORD_W-1:0] l_long;
      logic [COORD_W-1:0] l_short;
      logic [COORD_W-1:0] r_long;
      logic [COORD_W-1:0] r_short;
      logic [COORD_W-1:0] min_h;
      logic [COORD_W-1:0] max_h;
      logic [COORD_W-1:0] dy_abs;
      logic [COORD_W-1:0] h_gap;
      logic [ANGLE_W-1:0] angle_abs;
      logic [WHOLE_W-1:0] dxi;
      logic [WHOLE_W-1:0] dyi;
   } s1_type;

   typedef struct packed {
      logic                    first_is_left;
      logic                    not_coincident;
      logic [TENTH_W-1:0]      l_long10;
      logic [TENTH_W-1:0]      l_short10;
      logic [PROD_W-1:0]       hr_max_prod;
      logic [PROD_W-1:0]       hr_min_prod;
      logic [PROD_W-1:0]       wr_max_prod;
      logic [PROD_W-1:0]       wr_min_prod;
      logic [TENTH_W-1:0]      dy10;
      logic [PROD_W-1:0]       y_gate;
      logic [TENTH_W-1:0]      h_gap10;
      logic [PROD_W-1:0]       h_gate;
      logic [ANGLE10_W-1:0]    angle10;
      logic [ANGLE_GATE_W-1:0] angle_gate;
      logic [SQ_W-1:0]         sq_dx;
      logic [SQ_W-1:0]         sq_dy;
      logic [MH2_W-1:0]        mh2;
      logic [KT2_W-1:0]        kt2;
   } s2_type;

   typedef struct packed {
      logic             first_is_left;
      logic             gates_ok;
      logic [LHS_W-1:0] lhs;
      logic [THR_W-1:0] thr_small;
      logic [THR_W-1:0] thr_split;
      logic [THR_W-1:0] thr_large;
   } s3_type;

   // Rounds a fixed-point value to the nearest whole pixel, ties to even.
   function automatic logic [WHOLE_W-1:0] round_whole(input logic [COORD_W-1:0] v);
      logic [WHOLE_W-1:0]   ip;
      logic [FRAC_BITS-1:0] frac;
      logic [FRAC_BITS-1:0] half;
      ip = WHOLE_W'(v >> FRAC_BITS);
      frac = v[FRAC_BITS-1:0];
      half = FRAC_BITS'(1 << (FRAC_BITS - 1));
      if (frac > half || (frac == half && ip[0])) begin
         ip = ip + 1'b1;
      end
      return ip;
   endfunction

   function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

endpackage

`default_nettype wire

// File: rtl/lbpm_prep.sv
// First pipeline stage: orders the two lights left and right and derives
// sides, offsets, angle gap and rounded center distances. Uses lbpm_pkg.
`default_nettype none

module lbpm_prep (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire lbpm_pkg::req_word_type in_word,
   input  wire logic                  out_ready,
   output logic                       in_ready,
   output logic                       out_valid,
   output lbpm_pkg::s1_type           out_word
);

   logic                                 valid_ff;
   lbpm_pkg::s1_type                     word_ff;
   lbpm_pkg::s1_type                     word_in;
   logic                                 first_left;
   logic [lbpm_pkg::COORD_W-1:0]         lx, ly, lw, lh, rx, ry, rw, rh;
   logic signed [lbpm_pkg::ANGLE_W-1:0]  la, ra;
   logic signed [lbpm_pkg::ANGLE_W:0]    angle_diff;
   logic [lbpm_pkg::ANGLE_W:0]           angle_mag;

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word = word_ff;

   always_comb begin
      first_left = in_word.first_x <= in_word.second_x;
      lx = first_left ? in_word.first_x : in_word.second_x;
      ly = first_left ? in_word.first_y : in_word.second_y;
      lw = first_left ? in_word.first_w : in_word.second_w;
      lh = first_left ? in_word.first_h : in_word.second_h;
      la = first_left ? in_word.first_angle : in_word.second_angle;
      rx = first_left ? in_word.second_x : in_word.first_x;
      ry = first_left ? in_word.second_y : in_word.first_y;
      rw = first_left ? in_word.second_w : in_word.first_w;
      rh = first_left ? in_word.second_h : in_word.first_h;
      ra = first_left ? in_word.second_angle : in_word.first_angle;

      angle_diff = {la[lbpm_pkg::ANGLE_W-1], la} - {ra[lbpm_pkg::ANGLE_W-1], ra};
      angle_mag = angle_diff[lbpm_pkg::ANGLE_W] ? -angle_diff : angle_diff;

      word_in.first_is_left = first_left;
      word_in.not_coincident = !(in_word.first_x == in_word.second_x &&
                                 in_word.first_y == in_word.second_y);
      word_in.l_long = (lw > lh) ? lw : lh;
      word_in.l_short = (lw < lh) ? lw : lh;
      word_in.r_long = (rw > rh) ? rw : rh;
      word_in.r_short = (rw < rh) ? rw : rh;
      word_in.min_h = (lh < rh) ? lh : rh;
      word_in.max_h = (lh > rh) ? lh : rh;
      word_in.dy_abs = lbpm_pkg::abs_diff(ly, ry);
      word_in.h_gap = lbpm_pkg::abs_diff(lh, rh);
      word_in.angle_abs = angle_mag[lbpm_pkg::ANGLE_W-1:0];
      word_in.dxi = lbpm_pkg::WHOLE_W'(lbpm_pkg::abs_diff(
                       lbpm_pkg::COORD_W'(lbpm_pkg::round_whole(lx)),
                       lbpm_pkg::COORD_W'(lbpm_pkg::round_whole(rx))));
      word_in.dyi = lbpm_pkg::WHOLE_W'(lbpm_pkg::abs_diff(
                       lbpm_pkg::COORD_W'(lbpm_pkg::round_whole(ly)),
                       lbpm_pkg::COORD_W'(lbpm_pkg::round_whole(ry))));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/lbpm_mult.sv
// Second pipeline stage: forms the products of sides and limits and the
// squares used by the aspect test. Uses lbpm_pkg.
`default_nettype none

module lbpm_mult (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire lbpm_pkg::cfg_type cfg,
   input  wire logic             in_valid,
   input  wire lbpm_pkg::s1_type in_word,
   input  wire logic             out_ready,
   output logic                  in_ready,
   output logic                  out_valid,
   output lbpm_pkg::s2_type      out_word
);

   localparam int TW = lbpm_pkg::TENTH_W;
   localparam int PW = lbpm_pkg::PROD_W;
   localparam int SW = lbpm_pkg::SQ_W;
   localparam int MW = lbpm_pkg::MH2_W;
   localparam int KW = lbpm_pkg::KT2_W;
   localparam int AW = lbpm_pkg::ANGLE10_W;
   localparam int GW = lbpm_pkg::ANGLE_GATE_W;

   logic             valid_ff;
   lbpm_pkg::s2_type word_ff;
   lbpm_pkg::s2_type word_in;

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word = word_ff;

   always_comb begin
      word_in.first_is_left = in_word.first_is_left;
      word_in.not_coincident = in_word.not_coincident;
      word_in.l_long10 = TW'(in_word.l_long) * TW'(lbpm_pkg::TENTH_SCALE);
      word_in.l_short10 = TW'(in_word.l_short) * TW'(lbpm_pkg::TENTH_SCALE);
      word_in.hr_max_prod = PW'(cfg.height_ratio_max) * PW'(in_word.r_long);
      word_in.hr_min_prod = PW'(cfg.height_ratio_min) * PW'(in_word.r_long);
      word_in.wr_max_prod = PW'(cfg.width_ratio_max) * PW'(in_word.r_short);
      word_in.wr_min_prod = PW'(cfg.width_ratio_min) * PW'(in_word.r_short);
      word_in.dy10 = TW'(in_word.dy_abs) * TW'(lbpm_pkg::TENTH_SCALE);
      word_in.y_gate = PW'(in_word.min_h) * PW'(cfg.y_offset_limit);
      word_in.h_gap10 = TW'(in_word.h_gap) * TW'(lbpm_pkg::TENTH_SCALE);
      word_in.h_gate = PW'(in_word.min_h) * PW'(cfg.height_gap_limit);
      word_in.angle10 = AW'(in_word.angle_abs) * AW'(lbpm_pkg::TENTH_SCALE);
      word_in.angle_gate = GW'(cfg.angle_gap_limit) << lbpm_pkg::FRAC_BITS;
      word_in.sq_dx = SW'(in_word.dxi) * SW'(in_word.dxi);
      word_in.sq_dy = SW'(in_word.dyi) * SW'(in_word.dyi);
      word_in.mh2 = MW'(in_word.max_h) * MW'(in_word.max_h);
      word_in.kt2 = KW'(cfg.type_split) * KW'(cfg.type_split);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/lbpm_cmp.sv
// Third pipeline stage: decides the five shape gates and forms the scaled
// squared distance and the three squared aspect thresholds. Uses lbpm_pkg.
`default_nettype none

module lbpm_cmp (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire lbpm_pkg::s2_type in_word,
   input  wire logic             out_ready,
   output logic                  in_ready,
   output logic                  out_valid,
   output lbpm_pkg::s3_type      out_word
);

   localparam int PW = lbpm_pkg::PROD_W;
   localparam int LW = lbpm_pkg::LHS_W;
   localparam int HW = lbpm_pkg::THR_W;

   logic                         valid_ff;
   lbpm_pkg::s3_type             word_ff;
   lbpm_pkg::s3_type             word_in;
   logic [lbpm_pkg::SUM_W-1:0]   d2;
   logic                         ratio_ok;
   logic                         offset_ok;

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word = word_ff;

   always_comb begin
      ratio_ok = (PW'(in_word.l_long10) < in_word.hr_max_prod) &&
                 (PW'(in_word.l_long10) > in_word.hr_min_prod) &&
                 (PW'(in_word.l_short10) < in_word.wr_max_prod) &&
                 (PW'(in_word.l_short10) > in_word.wr_min_prod);
      offset_ok = (PW'(in_word.dy10) < in_word.y_gate) &&
                  (PW'(in_word.h_gap10) < in_word.h_gate) &&
                  (in_word.angle10 < lbpm_pkg::ANGLE10_W'(in_word.angle_gate));
      d2 = lbpm_pkg::SUM_W'(in_word.sq_dx) + lbpm_pkg::SUM_W'(in_word.sq_dy);

      word_in.first_is_left = in_word.first_is_left;
      word_in.gates_ok = in_word.not_coincident && ratio_ok && offset_ok;
      word_in.lhs = LW'(d2) * LW'(lbpm_pkg::ASPECT_SCALE);
      word_in.thr_small = HW'(in_word.mh2) * HW'(lbpm_pkg::SMALL_SQ);
      word_in.thr_split = HW'(in_word.kt2) * HW'(in_word.mh2);
      word_in.thr_large = HW'(in_word.mh2) * HW'(lbpm_pkg::LARGE_SQ);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/light_bar_pair_matcher_core.sv
// Top level of the light-bar pair matcher: register file, three pipeline
// stages and the aspect classing output stage. Uses lbpm_pkg and lbpm_* stages.
//
//   Port group   Direction   Handshake           Word
//   req_*        in          req_valid/req_stall lbpm_pkg::req_word_type
//   rsp_*        out         rsp_valid/rsp_stall lbpm_pkg::rsp_word_type
//   csr_*        in          csr_write_enable    index 3 bits, data 11 bits
//
// One word enters per cycle while req_stall is low; each result is registered in
// turn by the stages: order, multiply, compare, then aspect class.
// Reset clears all valid bits and loads the register defaults.
// A stalled result holds in the output register; earlier stages keep filling
// their empty slots, and req_stall rises only when all four stages are full.
`default_nettype none

module light_bar_pair_matcher_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire lbpm_pkg::req_word_type                req_word,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output lbpm_pkg::rsp_word_type                     rsp_word,
   input  wire logic                                  csr_write_enable,
   input  wire logic [lbpm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [lbpm_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   localparam int HW = lbpm_pkg::THR_W;

   lbpm_pkg::cfg_type      cfg_ff;
   lbpm_pkg::cfg_type      cfg_in;
   logic                   s1_ready, s2_ready, s3_ready, out_ready;
   logic                   s1_valid, s2_valid, s3_valid;
   lbpm_pkg::s1_type       s1_word;
   lbpm_pkg::s2_type       s2_word;
   lbpm_pkg::s3_type       s3_word;
   logic                   rsp_valid_ff;
   lbpm_pkg::rsp_word_type rsp_word_ff;
   lbpm_pkg::rsp_word_type rsp_word_in;
   logic [HW-1:0]          lhs_ext;
   logic                   small_cls;
   logic                   large_cls;
   logic                   matched;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (lbpm_pkg::csr_index_type'(csr_index))
            lbpm_pkg::CSR_HEIGHT_RATIO_MIN: cfg_in.height_ratio_min = csr_write_data[7:0];
            lbpm_pkg::CSR_HEIGHT_RATIO_MAX: cfg_in.height_ratio_max = csr_write_data[7:0];
            lbpm_pkg::CSR_WIDTH_RATIO_MIN:  cfg_in.width_ratio_min = csr_write_data[7:0];
            lbpm_pkg::CSR_WIDTH_RATIO_MAX:  cfg_in.width_ratio_max = csr_write_data[7:0];
            lbpm_pkg::CSR_Y_OFFSET_LIMIT:   cfg_in.y_offset_limit = csr_write_data[7:0];
            lbpm_pkg::CSR_HEIGHT_GAP_LIMIT: cfg_in.height_gap_limit = csr_write_data[7:0];
            lbpm_pkg::CSR_ANGLE_GAP_LIMIT:  cfg_in.angle_gap_limit = csr_write_data;
            lbpm_pkg::CSR_TYPE_SPLIT:       cfg_in.type_split = csr_write_data[7:0];
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= lbpm_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lbpm_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_word   (req_word),
      .out_ready (s2_ready),
      .in_ready  (s1_ready),
      .out_valid (s1_valid),
      .out_word  (s1_word)
   );

   lbpm_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (s1_valid),
      .in_word   (s1_word),
      .out_ready (s3_ready),
      .in_ready  (s2_ready),
      .out_valid (s2_valid),
      .out_word  (s2_word)
   );

   lbpm_cmp u_cmp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_word   (s2_word),
      .out_ready (out_ready),
      .in_ready  (s3_ready),
      .out_valid (s3_valid),
      .out_word  (s3_word)
   );

   assign req_stall = !s1_ready;
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      lhs_ext = HW'(s3_word.lhs);
      small_cls = (lhs_ext > s3_word.thr_small) && (lhs_ext < s3_word.thr_split);
      large_cls = !small_cls && (lhs_ext > s3_word.thr_split) &&
                  (lhs_ext < s3_word.thr_large);
      matched = s3_word.gates_ok && (small_cls || large_cls);
      rsp_word_in.pair_matched = matched;
      rsp_word_in.large_plate = matched && large_cls;
      rsp_word_in.first_is_left = s3_word.first_is_left;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s3_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s3_valid) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

   a_large_needs_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_word_ff.large_plate || rsp_word_ff.pair_matched))
      else $error("large plate flagged on an unmatched pair");

   a_accept_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid)
      else $error("accepted word did not enter the first stage");

   a_full_pipe_stalls: assert property (@(posedge clock) disable iff (reset)
      (s1_valid && s2_valid && s3_valid && rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("input taken while every stage is full and the output is stalled");

   a_cfg_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (cfg_ff == lbpm_pkg::CFG_RESET))
      else $error("register defaults not loaded by reset");

endmodule

`default_nettype wire
